// ===== rtl/core/wdbb_pkg.sv =====
// Package for the wall docking controller: item kinds, register map, reset values.
`timescale 1ns / 1ps
`default_nettype none

package wdbb_pkg;

  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_START  = 2'd1,
    FUNC_UPDATE = 2'd2
  } func_e;

  // Register byte addresses are 4*index; word index decoded from paddr[4:2].
  localparam int unsigned AddrW = 5;

  typedef enum logic [2:0] {
    REG_LEFT_GAIN    = 3'd0,
    REG_LEFT_OFFSET  = 3'd1,
    REG_RIGHT_GAIN   = 3'd2,
    REG_RIGHT_OFFSET = 3'd3,
    REG_TOLERANCE    = 3'd4,
    REG_DRIVE_SPEED  = 3'd5,
    REG_TIMEOUT      = 3'd6
  } reg_idx_e;

  localparam int unsigned GainW  = 16;
  localparam int unsigned DistW  = 20;
  localparam int unsigned TolW   = 19;
  localparam int unsigned SpeedW = 15;
  localparam int unsigned TmoW   = 16;
  localparam int unsigned CntW   = 4;

  localparam logic signed [GainW-1:0] GainReset   = 16'sd4096;
  localparam logic signed [DistW-1:0] OffsetReset = 20'sd0;
  localparam logic [TolW-1:0]         TolReset    = 19'd16;
  localparam logic [SpeedW-1:0]       SpeedReset  = 15'd50;
  localparam logic [TmoW-1:0]         TmoReset    = 16'd2000;

  // Consecutive stale updates that end docking with failure.
  localparam logic [CntW-1:0] StaleLimit = 4'd10;
  localparam logic [CntW-1:0] StaleMax   = 4'd15;

endpackage

`default_nettype wire

// ===== rtl/core/wdbb_cal.sv =====
// Range sensor calibration: (raw*gain >>> 12) + offset, saturated to 20 bits signed.
`timescale 1ns / 1ps
`default_nettype none

module wdbb_cal (
  input  logic signed [wdbb_pkg::GainW-1:0] raw_i,
  input  logic signed [wdbb_pkg::GainW-1:0] gain_i,
  input  logic signed [wdbb_pkg::DistW-1:0] offset_i,
  output logic signed [wdbb_pkg::DistW-1:0] dist_o
);

  logic signed [2*wdbb_pkg::GainW-1:0] prod;
  logic signed [wdbb_pkg::DistW-1:0]   scaled;
  logic signed [wdbb_pkg::DistW:0]     sum;

  assign prod   = raw_i * gain_i;
  // upper bits of the product are the floor shift by 12
  assign scaled = prod[2*wdbb_pkg::GainW-1:12];
  assign sum    = {scaled[wdbb_pkg::DistW-1], scaled}
                + {offset_i[wdbb_pkg::DistW-1], offset_i};

  always_comb begin
    if (sum[wdbb_pkg::DistW] != sum[wdbb_pkg::DistW-1]) begin
      dist_o = sum[wdbb_pkg::DistW] ? {1'b1, {(wdbb_pkg::DistW-1){1'b0}}}
                                    : {1'b0, {(wdbb_pkg::DistW-1){1'b1}}};
    end else begin
      dist_o = sum[wdbb_pkg::DistW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/wall_docking_bang_bang_controller_unit.sv =====
// Top level of the wall docking bang-bang controller.
//
//  channel   direction  handshake                 payload
//  s_axis    in         tvalid / tready           tuser = func, tdata = time, raws, target
//  m_axis    out        tvalid / tready           tdata = velocity, tlast = finished,
//                                                 tuser = success
//  apb       in / out   psel, penable, pready     7 registers at 4*index
//
// One request per cycle sustained unless a held result stalls the input. A request is
// held in the input register, then the calibration multiply, average, staleness and
// band compare update the state and load the result register.
// Only updates while docking make results; others never wait on m_axis.
// A held result stalls the input only when the next request also makes a result.
// Reset clears state, config to defaults, and both valid flags.
`timescale 1ns / 1ps
`default_nettype none

module wall_docking_bang_bang_controller_unit (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,   // now_ms[31:0], left_raw[47:32], right_raw[63:48],
                                      // target_distance[83:64], zero pad[87:84]
  input  logic [1:0]  s_axis_tuser,   // func[1:0]

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // drive_velocity[15:0]
  output logic        m_axis_tlast,   // finished
  output logic        m_axis_tuser,   // success[0]

  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wdbb_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  // ---------------- configuration ----------------
  logic signed [wdbb_pkg::GainW-1:0] lgain_q, rgain_q;
  logic signed [wdbb_pkg::DistW-1:0] loff_q, roff_q;
  logic [wdbb_pkg::TolW-1:0]         tol_q;
  logic [wdbb_pkg::SpeedW-1:0]       speed_q;
  logic [wdbb_pkg::TmoW-1:0]         tmo_q;
  logic                              cfg_wr;
  wdbb_pkg::reg_idx_e                cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = wdbb_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lgain_q <= wdbb_pkg::GainReset;
      loff_q  <= wdbb_pkg::OffsetReset;
      rgain_q <= wdbb_pkg::GainReset;
      roff_q  <= wdbb_pkg::OffsetReset;
      tol_q   <= wdbb_pkg::TolReset;
      speed_q <= wdbb_pkg::SpeedReset;
      tmo_q   <= wdbb_pkg::TmoReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        wdbb_pkg::REG_LEFT_GAIN:    lgain_q <= pwdata[15:0];
        wdbb_pkg::REG_LEFT_OFFSET:  loff_q  <= pwdata[19:0];
        wdbb_pkg::REG_RIGHT_GAIN:   rgain_q <= pwdata[15:0];
        wdbb_pkg::REG_RIGHT_OFFSET: roff_q  <= pwdata[19:0];
        wdbb_pkg::REG_TOLERANCE:    tol_q   <= pwdata[18:0];
        wdbb_pkg::REG_DRIVE_SPEED:  speed_q <= pwdata[14:0];
        wdbb_pkg::REG_TIMEOUT:      tmo_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      wdbb_pkg::REG_LEFT_GAIN:    prdata = {{16{lgain_q[15]}}, lgain_q};
      wdbb_pkg::REG_LEFT_OFFSET:  prdata = {{12{loff_q[19]}}, loff_q};
      wdbb_pkg::REG_RIGHT_GAIN:   prdata = {{16{rgain_q[15]}}, rgain_q};
      wdbb_pkg::REG_RIGHT_OFFSET: prdata = {{12{roff_q[19]}}, roff_q};
      wdbb_pkg::REG_TOLERANCE:    prdata = {13'd0, tol_q};
      wdbb_pkg::REG_DRIVE_SPEED:  prdata = {17'd0, speed_q};
      wdbb_pkg::REG_TIMEOUT:      prdata = {16'd0, tmo_q};
      default:                    prdata = 32'd0;
    endcase
  end

  // ---------------- input register ----------------
  logic                              s1_valid_q;
  wdbb_pkg::func_e                   s1_func_q;
  logic [31:0]                       s1_now_q;
  logic signed [wdbb_pkg::GainW-1:0] s1_left_q, s1_right_q;
  logic signed [wdbb_pkg::DistW-1:0] s1_target_q;
  logic                              in_acc;
  logic                              advance;
  logic                              makes_res;
  logic                              out_free;

  assign s_axis_tready = !s1_valid_q || advance;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_func_q   <= wdbb_pkg::func_e'(s_axis_tuser);
      s1_now_q    <= s_axis_tdata[31:0];
      s1_left_q   <= s_axis_tdata[47:32];
      s1_right_q  <= s_axis_tdata[63:48];
      s1_target_q <= s_axis_tdata[83:64];
    end
  end

  // ---------------- state ----------------
  logic                              active_q, active_d;
  logic signed [wdbb_pkg::DistW-1:0] avg_q, avg_d;
  logic [31:0]                       last_q, last_d;
  logic [wdbb_pkg::CntW-1:0]         cnt_q, cnt_d;
  logic signed [wdbb_pkg::DistW-1:0] target_q, target_d;

  logic signed [wdbb_pkg::DistW-1:0] cal_l, cal_r;
  logic signed [wdbb_pkg::DistW:0]   pair_sum;
  logic [31:0]                       age;
  logic                              stale;
  logic signed [wdbb_pkg::DistW:0]   err;
  logic [wdbb_pkg::DistW:0]          err_abs;
  logic                              far;
  logic [wdbb_pkg::CntW-1:0]         cnt_inc;
  logic [15:0]                       vel_d;
  logic                              fin_d, suc_d;

  wdbb_cal u_cal_left (
    .raw_i    (s1_left_q),
    .gain_i   (lgain_q),
    .offset_i (loff_q),
    .dist_o   (cal_l)
  );

  wdbb_cal u_cal_right (
    .raw_i    (s1_right_q),
    .gain_i   (rgain_q),
    .offset_i (roff_q),
    .dist_o   (cal_r)
  );

  assign pair_sum = {cal_l[wdbb_pkg::DistW-1], cal_l} + {cal_r[wdbb_pkg::DistW-1], cal_r};
  assign age      = s1_now_q - last_q;
  assign stale    = age > {16'd0, tmo_q};
  assign err      = {target_q[wdbb_pkg::DistW-1], target_q}
                  - {avg_q[wdbb_pkg::DistW-1], avg_q};
  assign err_abs  = err[wdbb_pkg::DistW] ? -err : err;
  assign far      = err_abs > {2'b00, tol_q};
  assign cnt_inc  = (cnt_q == wdbb_pkg::StaleMax) ? cnt_q : cnt_q + 4'd1;

  assign makes_res = s1_valid_q && (s1_func_q == wdbb_pkg::FUNC_UPDATE) && active_q;
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign advance   = s1_valid_q && (!makes_res || out_free);

  always_comb begin
    active_d = active_q;
    avg_d    = avg_q;
    last_d   = last_q;
    cnt_d    = cnt_q;
    target_d = target_q;
    vel_d    = 16'd0;
    fin_d    = 1'b0;
    suc_d    = 1'b0;
    unique case (s1_func_q)
      wdbb_pkg::FUNC_SAMPLE: begin
        avg_d  = pair_sum[wdbb_pkg::DistW:1];
        last_d = s1_now_q;
      end
      wdbb_pkg::FUNC_START: begin
        active_d = 1'b1;
        target_d = s1_target_q;
        cnt_d    = '0;
      end
      wdbb_pkg::FUNC_UPDATE: begin
        if (active_q) begin
          priority if (stale) begin
            cnt_d = cnt_inc;
            if (cnt_inc >= wdbb_pkg::StaleLimit) begin
              active_d = 1'b0;
              fin_d    = 1'b1;
            end
          end else if (far) begin
            // bang-bang: back off when closer than target, else approach
            vel_d = (avg_q < target_q) ? -{1'b0, speed_q} : {1'b0, speed_q};
            cnt_d = '0;
          end else begin
            active_d = 1'b0;
            fin_d    = 1'b1;
            suc_d    = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      avg_q    <= '0;
      last_q   <= '0;
      cnt_q    <= '0;
      target_q <= '0;
    end else if (advance) begin
      active_q <= active_d;
      avg_q    <= avg_d;
      last_q   <= last_d;
      cnt_q    <= cnt_d;
      target_q <= target_d;
    end
  end

  // ---------------- result register ----------------
  logic        out_valid_q;
  logic [15:0] out_vel_q;
  logic        out_fin_q, out_suc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && makes_res) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && makes_res) begin
      out_vel_q <= vel_d;
      out_fin_q <= fin_d;
      out_suc_q <= suc_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_vel_q;
  assign m_axis_tlast  = out_fin_q;
  assign m_axis_tuser  = out_suc_q;

`ifndef NO_ASSERTIONS
  a_res_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(makes_res))
    else $error("result without a docking update");

  a_success_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_suc_q) |-> (out_fin_q && out_vel_q == 16'd0))
    else $error("success result not a finished stop");

  a_finish_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && makes_res && fin_d) |=> !active_q)
    else $error("docking still armed after finish");

  a_stale_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= wdbb_pkg::StaleLimit)
    else $error("stale count past limit");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/wall_docking_bang_bang_controller_unit_tb.sv =====
// Self-checking testbench for the wall docking bang-bang controller unit.
`timescale 1ns / 1ps

module wall_docking_bang_bang_controller_unit_tb;

  localparam logic [1:0] FuncUnused = 2'd3;
  localparam int IdleLimit  = 2000;
  localparam int DrainTail  = 4;
  localparam int PhaseItems = 250;
  localparam int NumPhases  = 7;
  localparam int DistMax    = (1 << (wdbb_pkg::DistW - 1)) - 1;

  typedef struct packed {
    logic signed [15:0] velocity;
    logic               finished;
    logic               success;
  } drive_cmd_t;

  // Tracks the controller state and the drive commands it still owes.
  class docking_checker;
    logic signed [15:0] gain_l, gain_r;
    logic signed [19:0] ofs_l, ofs_r;
    logic [18:0]        tol;
    logic [14:0]        speed;
    logic [15:0]        tmo;
    logic               docking;
    logic signed [19:0] avg_dist, target;
    logic [31:0]        sample_ms;
    logic [3:0]         stale_cnt;
    drive_cmd_t         cmd_due[$];
    int                 errors;

    function new();
      gain_l    = wdbb_pkg::GainReset;
      gain_r    = wdbb_pkg::GainReset;
      ofs_l     = wdbb_pkg::OffsetReset;
      ofs_r     = wdbb_pkg::OffsetReset;
      tol       = wdbb_pkg::TolReset;
      speed     = wdbb_pkg::SpeedReset;
      tmo       = wdbb_pkg::TmoReset;
      docking   = 1'b0;
      avg_dist  = '0;
      target    = '0;
      sample_ms = '0;
      stale_cnt = '0;
      errors    = 0;
    endfunction

    function void set_register(wdbb_pkg::reg_idx_e idx, logic [31:0] value);
      case (idx)
        wdbb_pkg::REG_LEFT_GAIN:    gain_l = value[15:0];
        wdbb_pkg::REG_LEFT_OFFSET:  ofs_l  = value[19:0];
        wdbb_pkg::REG_RIGHT_GAIN:   gain_r = value[15:0];
        wdbb_pkg::REG_RIGHT_OFFSET: ofs_r  = value[19:0];
        wdbb_pkg::REG_TOLERANCE:    tol    = value[18:0];
        wdbb_pkg::REG_DRIVE_SPEED:  speed  = value[14:0];
        wdbb_pkg::REG_TIMEOUT:      tmo    = value[15:0];
        default: ;
      endcase
    endfunction

    // (raw*gain >>> 12) + offset, clamped to the 20-bit distance range
    function int calibrate(logic signed [15:0] raw, logic signed [15:0] gain,
                           logic signed [19:0] ofs);
      int v, lim;
      lim = (1 << (wdbb_pkg::DistW - 1)) - 1;
      v = ((int'(raw) * int'(gain)) >>> 12) + int'(ofs);
      if (v > lim) v = lim;
      if (v < -lim - 1) v = -lim - 1;
      return v;
    endfunction

    function void take_request(logic [1:0] func, logic [31:0] now,
                               logic signed [15:0] lraw, logic signed [15:0] rraw,
                               logic signed [19:0] tgt);
      drive_cmd_t cmd;
      int err;
      cmd = '0;
      case (func)
        wdbb_pkg::FUNC_SAMPLE: begin
          avg_dist  = 20'((calibrate(lraw, gain_l, ofs_l) +
                           calibrate(rraw, gain_r, ofs_r)) >>> 1);
          sample_ms = now;
        end
        wdbb_pkg::FUNC_START: begin
          docking   = 1'b1;
          target    = tgt;
          stale_cnt = '0;
        end
        wdbb_pkg::FUNC_UPDATE: begin
          if (docking) begin
            if (now - sample_ms > 32'(tmo)) begin
              if (stale_cnt < wdbb_pkg::StaleMax) stale_cnt++;
              if (stale_cnt >= wdbb_pkg::StaleLimit) begin
                docking      = 1'b0;
                cmd.finished = 1'b1;
              end
            end else begin
              err = int'(target) - int'(avg_dist);
              if (err < 0) err = -err;
              if (err > int'(tol)) begin
                cmd.velocity = (avg_dist < target) ? -$signed({1'b0, speed})
                                                   : $signed({1'b0, speed});
                stale_cnt = '0;
              end else begin
                docking      = 1'b0;
                cmd.finished = 1'b1;
                cmd.success  = 1'b1;
              end
            end
            cmd_due = {cmd_due, cmd};
          end
        end
        default: ;
      endcase
    endfunction

    function void flag(string what, drive_cmd_t want, drive_cmd_t got);
      errors++;
      if (errors <= 10)
        $display("%0t %s: expected vel=%0d fin=%0b suc=%0b, got vel=%0d fin=%0b suc=%0b",
                 $time, what, want.velocity, want.finished, want.success,
                 got.velocity, got.finished, got.success);
    endfunction

    function void match_command(drive_cmd_t got);
      drive_cmd_t want;
      if (cmd_due.size() == 0) begin
        flag("command with none due", '0, got);
      end else begin
        want = cmd_due.pop_front();
        if (got.velocity !== want.velocity || got.finished !== want.finished ||
            got.success !== want.success)
          flag("command mismatch", want, got);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata;   // now_ms[31:0], left_raw[47:32], right_raw[63:48],
                               // target_distance[83:64], zero pad[87:84]
  logic [1:0]  s_axis_tuser;   // func[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // drive_velocity[15:0]
  logic        m_axis_tlast;   // finished
  logic        m_axis_tuser;   // success[0]
  logic                        psel, penable, pwrite;
  logic [wdbb_pkg::AddrW-1:0]  paddr;
  logic [31:0]                 pwdata, prdata;
  logic                        pready;

  docking_checker chk;
  int          n_items = 0;
  int          burst_left = 0;
  logic [31:0] now_ms;
  int          idle_cycles = 0;
  int          rx_cycle = 0;
  int          rx_mode = 0;

  wall_docking_bang_bang_controller_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Receiver stall pattern: one of four styles, re-picked at random as rx_cycle advances.
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 256 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (rx_cycle % 5 != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      chk.match_command({m_axis_tdata, m_axis_tlast, m_axis_tuser});
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [15:0] rnd16();
    return 16'($urandom());
  endfunction

  function automatic logic [19:0] rnd20();
    return 20'($urandom());
  endfunction

  function automatic logic signed [15:0] pick_raw();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      default: return rnd16();
    endcase
  endfunction

  // Target mostly near the current average so that in-band stops happen.
  function automatic logic signed [19:0] pick_target();
    int span, t;
    span = 2 * int'(chk.tol) + 8;
    case ($urandom_range(0, 3))
      0: t = int'($urandom_range(0, 2 * DistMax + 1)) - DistMax - 1;
      1: t = int'(chk.avg_dist) + ($urandom_range(0, 1) ? 1 : -1) *
             (int'(chk.tol) + int'($urandom_range(0, 1)));
      default: t = int'(chk.avg_dist) + int'($urandom_range(0, 2 * span)) - span;
    endcase
    if (t > DistMax) t = DistMax;
    if (t < -DistMax - 1) t = -DistMax - 1;
    return 20'(t);
  endfunction

  task automatic send_req(logic [1:0] func, logic [31:0] now, logic signed [15:0] lraw,
                          logic signed [15:0] rraw, logic signed [19:0] tgt);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
      burst_left = $urandom_range(1, 48);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    n_items++;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {4'b0, tgt, rraw, lraw, now};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    chk.take_request(func, now, lraw, rraw, tgt);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (chk.cmd_due.size() != 0) @(posedge clk_i);
    // requests without a command may still be in the pipe
    repeat (DrainTail) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic apb_write(wdbb_pkg::reg_idx_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= wdbb_pkg::AddrW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    chk.set_register(idx, value);
  endtask

  task automatic load_settings(logic [15:0] lg, logic [19:0] lo, logic [15:0] rg,
                               logic [19:0] ro, logic [18:0] tl, logic [14:0] sp,
                               logic [15:0] tm);
    apb_write(wdbb_pkg::REG_LEFT_GAIN,    {{16{lg[15]}}, lg});
    apb_write(wdbb_pkg::REG_LEFT_OFFSET,  {{12{lo[19]}}, lo});
    apb_write(wdbb_pkg::REG_RIGHT_GAIN,   {{16{rg[15]}}, rg});
    apb_write(wdbb_pkg::REG_RIGHT_OFFSET, {{12{ro[19]}}, ro});
    apb_write(wdbb_pkg::REG_TOLERANCE,    32'(tl));
    apb_write(wdbb_pkg::REG_DRIVE_SPEED,  32'(sp));
    apb_write(wdbb_pkg::REG_TIMEOUT,      32'(tm));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // One docking attempt: noise, a run of stale updates, or a normal approach.
  task automatic run_episode();
    int kind, sel;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 6))
        send_req(2'($urandom_range(0, 3)), $urandom(), rnd16(), rnd16(), rnd20());
    end else begin
      now_ms += $urandom_range(0, chk.tmo);
      send_req(wdbb_pkg::FUNC_SAMPLE, now_ms, pick_raw(), pick_raw(), rnd20());
      send_req(wdbb_pkg::FUNC_START, now_ms, rnd16(), rnd16(), pick_target());
      if (kind == 1) begin
        repeat ($urandom_range(10, 12)) begin
          now_ms += 32'(chk.tmo) + $urandom_range(1, 500);
          send_req(wdbb_pkg::FUNC_UPDATE, now_ms, rnd16(), rnd16(), rnd20());
        end
      end else begin
        repeat ($urandom_range(1, 14)) begin
          case ($urandom_range(0, 7))
            0:       now_ms += 32'(chk.tmo) + $urandom_range(1, 100);
            1:       now_ms += $urandom();
            default: now_ms += $urandom_range(0, chk.tmo / 4);
          endcase
          sel = $urandom_range(0, 9);
          if (sel < 3)
            send_req(wdbb_pkg::FUNC_SAMPLE, now_ms, pick_raw(), pick_raw(), rnd20());
          else if (sel == 3)
            send_req(wdbb_pkg::FUNC_START, now_ms, rnd16(), rnd16(), pick_target());
          else
            send_req(wdbb_pkg::FUNC_UPDATE, now_ms, rnd16(), rnd16(), rnd20());
        end
      end
    end
  endtask

  initial begin
    int goal;
    chk = new();
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle update, unused kind, raw extremes, both drive directions
    send_req(wdbb_pkg::FUNC_UPDATE, 32'd0, rnd16(), rnd16(), rnd20());
    send_req(FuncUnused, $urandom(), rnd16(), rnd16(), rnd20());
    send_req(wdbb_pkg::FUNC_SAMPLE, 32'd100, 16'sh7FFF, 16'sh7FFF, rnd20());
    send_req(wdbb_pkg::FUNC_START, 32'd100, rnd16(), rnd16(), 20'sh7FFFF);
    send_req(wdbb_pkg::FUNC_UPDATE, 32'd100, rnd16(), rnd16(), rnd20());
    send_req(wdbb_pkg::FUNC_START, 32'd100, rnd16(), rnd16(), 20'sh80000);
    // age equal to the timeout is still fresh
    send_req(wdbb_pkg::FUNC_UPDATE, 32'd2100, rnd16(), rnd16(), rnd20());
    send_req(wdbb_pkg::FUNC_SAMPLE, 32'd200, 16'sh8000, 16'sh8000, rnd20());
    // error exactly at the tolerance edge stops with success
    send_req(wdbb_pkg::FUNC_START, 32'd200, rnd16(), rnd16(), -20'sd32752);
    send_req(wdbb_pkg::FUNC_UPDATE, 32'd200, rnd16(), rnd16(), rnd20());
    send_req(wdbb_pkg::FUNC_START, 32'd200, rnd16(), rnd16(), 20'sd0);
    // ten stale updates in a row end with failure
    for (int k = 0; k < 10; k++)
      send_req(wdbb_pkg::FUNC_UPDATE, 32'd2201 + 32'(k), rnd16(), rnd16(), rnd20());
    // time wrap across 2^32
    send_req(wdbb_pkg::FUNC_SAMPLE, 32'hFFFF_FFF0, 16'sh7FFF, 16'sh8000, rnd20());
    send_req(wdbb_pkg::FUNC_START, 32'hFFFF_FFF0, rnd16(), rnd16(), 20'sd17);
    send_req(wdbb_pkg::FUNC_UPDATE, 32'h0000_0010, rnd16(), rnd16(), rnd20());
    send_req(wdbb_pkg::FUNC_START, 32'h0000_0010, rnd16(), rnd16(), -20'sd1);
    send_req(wdbb_pkg::FUNC_UPDATE, 32'h0000_0010, rnd16(), rnd16(), rnd20());

    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      case (p)
        1: load_settings(16'h7FFF, 20'h7FFFF, 16'h7FFF, 20'h7FFFF, 19'h7FFFF, 15'h7FFF,
                         16'hFFFF);
        2: load_settings(16'h8000, 20'h80000, 16'h8000, 20'h80000, 19'h0, 15'h0, 16'h0);
        3, 4, 6: load_settings(rnd16(), rnd20(), rnd16(), rnd20(),
                               ($urandom_range(0, 3) == 0) ? 19'($urandom())
                                                           : 19'($urandom_range(0, 255)),
                               15'($urandom()), rnd16());
        default: load_settings(16'(4096 + $urandom_range(0, 4096) - 2048),
                               20'(int'($urandom_range(0, 4095)) - 2048),
                               16'(4096 + $urandom_range(0, 4096) - 2048),
                               20'(int'($urandom_range(0, 4095)) - 2048),
                               19'($urandom_range(0, 64)), 15'($urandom()),
                               16'($urandom_range(100, 3000)));
      endcase
      now_ms = (p == 4) ? 32'hFFFF_F000 : $urandom();
      goal = n_items + PhaseItems;
      while (n_items < goal) run_episode();
    end

    wait_drained();
    if (chk.errors == 0 && chk.cmd_due.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
